/* hw/rtl/binned_min_frequency_priority_queues_core_defines.svh */
// assertion macros used by the checker file
`ifndef BINNED_MIN_FREQUENCY_PRIORITY_QUEUES_CORE_DEFINES_SVH
`define BINNED_MIN_FREQUENCY_PRIORITY_QUEUES_CORE_DEFINES_SVH
// implication checked on every clock edge outside reset
`define BMQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// implication checked in the cycle after the antecedent
`define BMQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hw/rtl/bmq_pkg.sv */
// package with record type, sizes, status, request and register codes and ordering function
package bmq_pkg;
  localparam int QueueDepth = 256;
  localparam int NumClasses = 4;
  localparam int AddrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int ClsW = 2;
  localparam int MemAw = AddrW + ClsW;

  localparam logic [1:0] ST_PUSHED = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_POPPED = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP = 1'b1;

  localparam logic [1:0] REG_TOP = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;
  localparam logic [1:0] REG_LOWER = 2'd2;

  typedef struct packed {
    logic [21:0] freq;
    logic [15:0] id;
    logic [15:0] mag;
  } rec_t;

  // a served before b: freq, then id, then magnitude, as one key
  function automatic logic rec_before(rec_t a, rec_t b);
    rec_before = a < b;
  endfunction
endpackage

/* hw/rtl/bmq_heap_ram.sv */
// heap record memory, one write and one registered read port
module bmq_heap_ram (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bmq_pkg::MemAw-1:0] waddr,
  input  bmq_pkg::rec_t             wdata,
  input  logic [bmq_pkg::MemAw-1:0] raddr,
  output bmq_pkg::rec_t             rdata
);
  bmq_pkg::rec_t mem [bmq_pkg::NumClasses*bmq_pkg::QueueDepth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* hw/rtl/binned_min_frequency_priority_queues_core.sv */
// top level: four binned min-heaps sharing one memory and one comparator
//
//   channel | signals                                    | dir
//   request | req_valid/req_ready, req_type..pop_class    | in
//   result  | rsp_valid/rsp_ready, status..out_magnitude  | out
//   config  | cfg_we, cfg_index, cfg_data                  | in
//
// push: per level S_PUSH reads the parent, S_UPCMP compares and moves; up to
// eight levels at depth 256
// pop: S_POPRT, S_POPLS and S_POPLD read root and last entry, then per level
// sifted down (left read, right read, pick child, compare and move), up to seven
// levels; full push or empty pop answers the next cycle; ready again the cycle
// after the result is taken
// rst clears counts and the state, loads default thresholds; memory holds no valid bits
// a stalled result holds the sequencer and outputs until rsp_ready
module binned_min_frequency_priority_queues_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic        req_type,
  input  logic [15:0] sample_id,
  input  logic [21:0] frequency,
  input  logic [15:0] magnitude,
  input  logic [1:0]  pop_class,
  output logic        rsp_valid,
  input  logic        rsp_ready,
  output logic [1:0]  status,
  output logic [1:0]  out_class,
  output logic [15:0] out_id,
  output logic [21:0] out_frequency,
  output logic [15:0] out_magnitude,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  localparam int AW = bmq_pkg::AddrW;
  localparam int CW = bmq_pkg::CntW;

  // sequencer states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PUSH   = 4'd1;  // decide next up step
  localparam logic [3:0] S_UPCMP  = 4'd2;  // parent data ready
  localparam logic [3:0] S_POPRT  = 4'd3;  // root read issued
  localparam logic [3:0] S_POPLS  = 4'd4;  // root data ready, last read issued
  localparam logic [3:0] S_POPLD  = 4'd5;  // last data ready
  localparam logic [3:0] S_DNSTEP = 4'd6;  // decide next down step
  localparam logic [3:0] S_DNC1   = 4'd7;  // left child data ready
  localparam logic [3:0] S_DNC2   = 4'd8;  // right child data ready
  localparam logic [3:0] S_DNC3   = 4'd9;  // best child against record
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [15:0] thr_top, thr_upper, thr_lower;
  logic [CW-1:0] counts [bmq_pkg::NumClasses];

  bmq_pkg::rec_t rec;     // record being placed
  bmq_pkg::rec_t best;    // best child so far
  logic [1:0] cls;
  logic [AW-1:0] pos;
  logic [AW-1:0] last;    // pop: index of the last entry
  logic [AW-1:0] child;   // chosen child index

  logic mem_we;
  logic [bmq_pkg::MemAw-1:0] mem_waddr, mem_raddr;
  bmq_pkg::rec_t mem_wdata, mem_rdata;

  bmq_heap_ram u_ram (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  // class picked by magnitude, first passing test wins
  logic [1:0] in_cls;
  always_comb begin
    if (magnitude >= thr_top) in_cls = 2'd3;
    else if (magnitude >= thr_upper) in_cls = 2'd2;
    else if (magnitude >= thr_lower) in_cls = 2'd1;
    else in_cls = 2'd0;
  end

  // heap index arithmetic, widened so depth-sized values fit
  logic [AW:0] lchild_w, rchild_w;
  logic [AW-1:0] parent;
  assign lchild_w = {pos, 1'b1};
  assign rchild_w = {pos, 1'b0} + (AW+1)'(2);
  assign parent = (pos - AW'(1)) >> 1;

  // the one shared comparator, operands picked by state
  bmq_pkg::rec_t cmp_a, cmp_b;
  logic cmp_lt;
  always_comb begin
    cmp_a = rec;
    cmp_b = mem_rdata;
    case (state)
      S_DNC2: begin
        cmp_a = mem_rdata;
        cmp_b = best;
      end
      S_DNC3: begin
        cmp_a = best;
        cmp_b = rec;
      end
      default: ;
    endcase
    cmp_lt = bmq_pkg::rec_before(cmp_a, cmp_b);
  end

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = (state == S_DONE);

  always_comb begin
    mem_we = 1'b0;
    mem_waddr = {cls, pos};
    mem_wdata = rec;
    mem_raddr = {cls, pos};
    case (state)
      S_PUSH: begin
        // at the root the record lands, otherwise fetch the parent
        if (pos == '0) mem_we = 1'b1;
        else mem_raddr = {cls, parent};
      end
      S_UPCMP: begin
        // move parent down when the new record wins, else place record
        mem_we = 1'b1;
        if (cmp_lt) mem_wdata = mem_rdata;
      end
      S_POPRT: mem_raddr = {cls, {AW{1'b0}}};
      S_POPLS: mem_raddr = {cls, last};
      S_DNSTEP: begin
        // no child left: place the record unless the heap is now empty
        if (lchild_w >= {1'b0, last}) mem_we = (last != '0);
        else mem_raddr = {cls, lchild_w[AW-1:0]};
      end
      S_DNC1: mem_raddr = {cls, rchild_w[AW-1:0]};
      S_DNC3: begin
        // move best child up when it wins, else place record
        mem_we = 1'b1;
        if (cmp_lt) mem_wdata = best;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      thr_top <= 16'd40000;
      thr_upper <= 16'd30000;
      thr_lower <= 16'd20000;
      for (int i = 0; i < bmq_pkg::NumClasses; i++) counts[i] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          bmq_pkg::REG_TOP: thr_top <= cfg_data;
          bmq_pkg::REG_UPPER: thr_upper <= cfg_data;
          bmq_pkg::REG_LOWER: thr_lower <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            out_id <= '0;
            out_frequency <= '0;
            out_magnitude <= '0;
            rec <= '{freq: frequency, id: sample_id, mag: magnitude};
            if (req_type == bmq_pkg::REQ_PUSH) begin
              cls <= in_cls;
              out_class <= in_cls;
              if (counts[in_cls] == CW'(bmq_pkg::QueueDepth)) begin
                status <= bmq_pkg::ST_FULL;
                state <= S_DONE;
              end else begin
                status <= bmq_pkg::ST_PUSHED;
                pos <= counts[in_cls][AW-1:0];
                counts[in_cls] <= counts[in_cls] + CW'(1);
                state <= S_PUSH;
              end
            end else begin
              cls <= pop_class;
              out_class <= pop_class;
              if (counts[pop_class] == '0) begin
                status <= bmq_pkg::ST_EMPTY;
                state <= S_DONE;
              end else begin
                status <= bmq_pkg::ST_POPPED;
                pos <= '0;
                last <= AW'(counts[pop_class] - CW'(1));
                counts[pop_class] <= counts[pop_class] - CW'(1);
                state <= S_POPRT;
              end
            end
          end
        end
        S_PUSH: begin
          if (pos == '0) begin
            // final placement at pos
            state <= S_DONE;
          end else begin
            state <= S_UPCMP;
          end
        end
        S_UPCMP: begin
          if (cmp_lt) begin
            pos <= parent;
            state <= S_PUSH;
          end else begin
            state <= S_DONE;
          end
        end
        S_POPRT: begin
          state <= S_POPLS;
        end
        S_POPLS: begin
          // root data arrives now
          out_id <= mem_rdata.id;
          out_frequency <= mem_rdata.freq;
          out_magnitude <= mem_rdata.mag;
          state <= S_POPLD;
        end
        S_POPLD: begin
          // last entry becomes the record sifted down from the root
          rec <= mem_rdata;
          state <= S_DNSTEP;
        end
        S_DNSTEP: begin
          if (lchild_w >= {1'b0, last}) begin
            state <= S_DONE;
          end else begin
            state <= S_DNC1;
          end
        end
        S_DNC1: begin
          best <= mem_rdata;
          state <= S_DNC2;
        end
        S_DNC2: begin
          // right child only counts when it lies inside the heap
          if (rchild_w < {1'b0, last} && cmp_lt) begin
            best <= mem_rdata;
            child <= rchild_w[AW-1:0];
          end else begin
            child <= lchild_w[AW-1:0];
          end
          state <= S_DNC3;
        end
        S_DNC3: begin
          if (cmp_lt) begin
            pos <= child;
            state <= S_DNSTEP;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (rsp_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* hw/rtl/bmq_checker.sv */
// port-level checker for the queue core, bound to the top level
`include "binned_min_frequency_priority_queues_core_defines.svh"
module bmq_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [1:0] status,
  input logic [15:0] out_id
);
  `BMQ_ASSERT_IMPL(a_busy, clk, rst, rsp_valid, !req_ready, "ready while result pending")
  `BMQ_ASSERT_NEXT(a_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(status), "result dropped")
  `BMQ_ASSERT_NEXT(a_one, clk, rst, req_valid && req_ready, !req_ready, "second request taken")
  `BMQ_ASSERT_IMPL(a_zero, clk, rst, rsp_valid && status != bmq_pkg::ST_POPPED, out_id == '0, "id not zero")
endmodule

bind binned_min_frequency_priority_queues_core bmq_checker u_chk (
  .clk(clk), .rst(rst), .req_valid(req_valid), .req_ready(req_ready),
  .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
  .status(status), .out_id(out_id)
);
